// ===== hw/rtl/lwub_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Latency window upper bound: shared definitions
// Widths, codes, state encoding and unit request/response structs used by
// the channel interfaces and every module of the block but the generic RAM.
// ----------------------------------------------------------------------------
package lwub_pkg;

   // Sample window
   localparam int WINDOW_DEPTH = 32;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

   // Datapath widths
   localparam int TIME_W  = 32;
   localparam int FLOOR_W = 20;
   localparam int SUM_W   = TIME_W + CNT_W;
   localparam int SQ_W    = 2 * TIME_W;
   localparam int ACC_W   = SQ_W + CNT_W;
   localparam int ROOT_W  = SQ_W / 2;

   // Shared divider and square root unit sizing
   localparam int DIV_W       = ACC_W;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS + 1);

   localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(10000);

   // Transaction codes
   localparam logic REQ_SEND  = 1'b0;
   localparam logic REQ_REPLY = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_PROBE = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SUM,
      ST_MEAN_DIV,
      ST_VAR,
      ST_VAR_DIV,
      ST_SQRT,
      ST_OUTPUT
   } lwub_state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [CNT_W-1:0]   divisor;
   } lwub_div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_W-1:0]   quotient;
      logic [CNT_W-1:0]   remainder;
   } lwub_div_rsp_type;

   typedef struct packed {
      logic               start;
      logic [SQ_W-1:0]    radicand;
   } lwub_sqrt_req_type;

   typedef struct packed {
      logic               done;
      logic [ROOT_W-1:0]  root;
   } lwub_sqrt_rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/lwub_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Probe send and probe reply transactions into the block.
// ----------------------------------------------------------------------------
interface lwub_req_if;
   import lwub_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [TIME_W-1:0] now_time;
   logic [TIME_W-1:0] reply_stamp;

   modport source (output valid, output req_type, output now_time, output reply_stamp,
                   input ready);
   modport sink   (input valid, input req_type, input now_time, input reply_stamp,
                   output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lwub_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// One transaction per probe reply: latencies, bound and status.
// ----------------------------------------------------------------------------
interface lwub_rsp_if;
   import lwub_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [TIME_W-1:0] one_way;
   logic signed [TIME_W-1:0] round_trip;
   logic signed [TIME_W-1:0] upper_bound;
   logic                     status;

   modport source (output valid, output one_way, output round_trip, output upper_bound,
                   output status, input ready);
   modport sink   (input valid, input one_way, input round_trip, input upper_bound,
                   input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lwub_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the bound floor register value.
// ----------------------------------------------------------------------------
interface lwub_csr_if;
   import lwub_pkg::*;

   logic               valid;
   logic               ready;
   logic [FLOOR_W-1:0] bound_floor_us;

   modport source (output valid, output bound_floor_us, input ready);
   modport sink   (input valid, input bound_floor_us, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lwub_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lwub_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/lwub_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned dividend by a small unsigned divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwub_div (
   input  logic                      clock,
   input  logic                      reset,
   input  lwub_pkg::lwub_div_req_type div_req,
   output lwub_pkg::lwub_div_rsp_type div_rsp
);
   import lwub_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [CNT_W-1:0]     dvs_ff;

   logic [CNT_W:0]       rem_sh;
   logic                 take;
   logic [CNT_W:0]       rem_in;

   // Trial subtraction of one step
   assign rem_sh = {rem_ff, quo_ff[DIV_W-1]};
   assign take   = (rem_sh >= {1'b0, dvs_ff});
   assign rem_in = take ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift dividend out, quotient in
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], take};
         rem_ff <= rem_in[CNT_W-1:0];
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished operation");

   a_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (div_req.divisor != '0))
      else $error("divider started with zero divisor");

endmodule
`default_nettype wire

// ===== hw/rtl/lwub_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer square root
// Floor square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module lwub_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  lwub_pkg::lwub_sqrt_req_type sqrt_req,
   output lwub_pkg::lwub_sqrt_rsp_type sqrt_rsp
);
   import lwub_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [SQRT_CNT_W-1:0] cnt_ff;
   logic [SQ_W-1:0]       rad_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [ROOT_W+1:0]     rem_ff;

   logic [ROOT_W+2:0]     rem_sh;
   logic [ROOT_W+2:0]     trial;
   logic                  take;
   logic [ROOT_W+2:0]     rem_in;

   // One digit of the root
   assign rem_sh = {rem_ff[ROOT_W:0], rad_ff[SQ_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign take   = (rem_sh >= trial);
   assign rem_in = take ? (rem_sh - trial) : rem_sh;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (sqrt_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= SQRT_CNT_W'(SQRT_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == SQRT_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Advance radicand, remainder and root
   always_ff @(posedge clock) begin
      if (sqrt_req.start) begin
         rad_ff  <= sqrt_req.radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[SQ_W-3:0], 2'b00};
         root_ff <= {root_ff[ROOT_W-2:0], take};
         rem_ff  <= rem_in[ROOT_W+1:0];
      end
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      sqrt_req.start |-> !busy_ff)
      else $error("square root started while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("square root done without a finished operation");

   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff[ROOT_W+1] == 1'b0))
      else $error("square root remainder exceeds twice the root");

endmodule
`default_nettype wire

// ===== hw/rtl/latency_window_upper_bound.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Latency window upper bound
// Tracks probe send times, turns replies into one-way and round-trip
// latencies and bounds the one-way latency over a sliding window by
// mean plus two standard deviations, raised to at least the bound floor.
// ----------------------------------------------------------------------------
// A send transaction leaves the block idle and ready for the next request.
// A reply without a pending probe goes straight to the output state. A reply to a
// pending probe writes its sample into the window RAM and then walks the
// newest n samples (n up to WINDOW_DEPTH) twice through the RAM's single read
// port, once for the sum and once for the squared deviations, runs the shared
// divider twice, over the DIV_W = 70 quotient bits each time, and the square
// root unit once before the result load, which is held back while the previous
// result still waits to be collected. The result sits in an output register,
// so a new request is taken while it waits to be collected. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module latency_window_upper_bound (
   input  logic              clock,
   input  logic              reset,
   lwub_req_if.sink          req_ch,
   lwub_rsp_if.source        rsp_ch,
   lwub_csr_if.sink          csr_ch
);
   import lwub_pkg::*;

   localparam logic signed [TIME_W-1:0] BOUND_MAX = {1'b0, {(TIME_W-1){1'b1}}};

   // Sequencer
   lwub_state_type state_ff, state_in;

   // Architectural state
   logic [FLOOR_W-1:0]       floor_ff;
   logic [IDX_W-1:0]         wr_idx_ff;
   logic [CNT_W-1:0]         fill_ff;
   logic                     pending_ff;
   logic [TIME_W-1:0]        send_time_ff;
   logic signed [TIME_W-1:0] last_bound_ff;

   // Working registers of one reply
   logic [TIME_W-1:0]        sample_ff;
   logic [TIME_W-1:0]        rt_ff;
   logic                     err_ff;
   logic [CNT_W-1:0]         rd_cnt_ff;
   logic                     rd_vld_ff;
   logic                     ad_vld_ff;
   logic                     sq_vld_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [TIME_W-1:0] mean_ff;
   logic [TIME_W-1:0]        ad_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [ACC_W-1:0]         acc_ff;

   // Result register
   logic                     rsp_valid_ff;
   logic signed [TIME_W-1:0] one_way_ff;
   logic signed [TIME_W-1:0] round_trip_ff;
   logic signed [TIME_W-1:0] upper_bound_ff;
   logic                     status_ff;

   // Control
   logic                     req_acc;
   logic                     rsp_free;
   logic                     issue;
   logic                     sum_done;
   logic                     var_done;
   logic                     req_ready;
   logic                     ram_we;
   logic                     rsp_load;
   logic [TIME_W-1:0]        ram_rdata;

   // Datapath helpers
   logic [SUM_W-1:0]         sum_mag;
   logic [TIME_W:0]          mean_q;
   logic [TIME_W:0]          mean_in;
   logic [TIME_W:0]          dev;
   logic [TIME_W:0]          dev_abs;
   logic [SQ_W-1:0]          sq_in;
   logic [TIME_W+2:0]        bound_wide;
   logic signed [TIME_W-1:0] bound_in;
   logic signed [TIME_W-1:0] floor_s;
   logic signed [TIME_W-1:0] upper_in;

   lwub_div_req_type         div_req;
   lwub_div_rsp_type         div_rsp;
   lwub_sqrt_req_type        sqrt_req;
   lwub_sqrt_rsp_type        sqrt_rsp;

   // Sample window memory
   lwub_ram #(
      .WIDTH (TIME_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (sample_ff),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   lwub_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lwub_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   // Handshake and pass status
   assign req_acc  = req_ch.valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign issue    = ((state_ff == ST_SUM) || (state_ff == ST_VAR)) && (rd_cnt_ff != fill_ff);
   assign sum_done = (state_ff == ST_SUM) && (rd_cnt_ff == fill_ff) && !rd_vld_ff;
   assign var_done = (state_ff == ST_VAR) && (rd_cnt_ff == fill_ff) && !rd_vld_ff
                     && !ad_vld_ff && !sq_vld_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_ch.req_type == REQ_REPLY)) begin
               state_in = pending_ff ? ST_WRITE : ST_OUTPUT;
            end
         end
         ST_WRITE: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_done) begin
               state_in = ST_MEAN_DIV;
            end
         end
         ST_MEAN_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            if (var_done) begin
               state_in = ST_VAR_DIV;
            end
         end
         ST_VAR_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_WRITE:  ram_we    = 1'b1;
         ST_OUTPUT: rsp_load  = rsp_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Divider and square root requests
   assign sum_mag          = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_req.start    = sum_done || var_done;
   assign div_req.dividend = (state_ff == ST_SUM) ? {{(DIV_W-SUM_W){1'b0}}, sum_mag}
                                                  : DIV_W'(acc_ff);
   assign div_req.divisor  = fill_ff;
   assign sqrt_req.start    = (state_ff == ST_VAR_DIV) && div_rsp.done;
   assign sqrt_req.radicand = div_rsp.quotient[SQ_W-1:0];

   // Floored mean: negate the magnitude quotient, one lower when inexact
   assign mean_q  = div_rsp.quotient[TIME_W:0];
   assign mean_in = sum_ff[SUM_W-1]
                    ? ((~mean_q) + {{TIME_W{1'b0}}, (div_rsp.remainder == '0)})
                    : mean_q;

   // Absolute deviation and its square
   assign dev     = {ram_rdata[TIME_W-1], ram_rdata} - {mean_ff[TIME_W-1], mean_ff};
   assign dev_abs = dev[TIME_W] ? (~dev + 1'b1) : dev;
   assign sq_in   = ad_ff * ad_ff;

   // Mean plus twice sigma, saturated to the signed range
   assign bound_wide = {{3{mean_ff[TIME_W-1]}}, mean_ff} + {2'b00, sqrt_rsp.root, 1'b0};
   assign bound_in   = (!bound_wide[TIME_W+2] && (bound_wide[TIME_W+1:TIME_W-1] != '0))
                       ? BOUND_MAX : $signed(bound_wide[TIME_W-1:0]);

   // Apply the floor register
   assign floor_s  = $signed({{(TIME_W-FLOOR_W){1'b0}}, floor_ff});
   assign upper_in = (last_bound_ff > floor_s) ? last_bound_ff : floor_s;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         floor_ff      <= FLOOR_RESET;
         wr_idx_ff     <= '0;
         fill_ff       <= '0;
         pending_ff    <= 1'b0;
         send_time_ff  <= '0;
         last_bound_ff <= '0;
         rd_cnt_ff     <= '0;
         rd_vld_ff     <= 1'b0;
         ad_vld_ff     <= 1'b0;
         sq_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         ad_vld_ff <= rd_vld_ff && (state_ff == ST_VAR);
         sq_vld_ff <= ad_vld_ff;

         // Load the floor register on a configuration write
         if (csr_ch.valid) begin
            floor_ff <= csr_ch.bound_floor_us;
         end

         // Record sends, retire the pending probe on a reply
         if (req_acc) begin
            if (req_ch.req_type == REQ_SEND) begin
               send_time_ff <= req_ch.now_time;
               pending_ff   <= 1'b1;
            end else begin
               pending_ff <= 1'b0;
            end
         end

         // Advance the ring pointer and fill level
         if (ram_we) begin
            wr_idx_ff <= (wr_idx_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
            if (fill_ff != CNT_W'(WINDOW_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end

         // Read counter: restart for each pass
         if (ram_we || ((state_ff == ST_MEAN_DIV) && div_rsp.done)) begin
            rd_cnt_ff <= '0;
         end else if (issue) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end

         if ((state_ff == ST_SQRT) && sqrt_rsp.done) begin
            last_bound_ff <= bound_in;
         end

         // Result register
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc && (req_ch.req_type == REQ_REPLY)) begin
         err_ff    <= !pending_ff;
         sample_ff <= pending_ff ? (req_ch.reply_stamp - send_time_ff) : '0;
         rt_ff     <= pending_ff ? (req_ch.now_time - send_time_ff) : '0;
      end

      if (ram_we) begin
         sum_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (rd_vld_ff && (state_ff == ST_SUM)) begin
            sum_ff <= sum_ff + {{(SUM_W-TIME_W){ram_rdata[TIME_W-1]}}, ram_rdata};
         end
         if (sq_vld_ff) begin
            acc_ff <= acc_ff + {{(ACC_W-SQ_W){1'b0}}, sq_ff};
         end
      end

      if ((state_ff == ST_MEAN_DIV) && div_rsp.done) begin
         mean_ff <= mean_in[TIME_W-1:0];
      end

      if (rd_vld_ff) begin
         ad_ff <= dev_abs[TIME_W-1:0];
      end
      if (ad_vld_ff) begin
         sq_ff <= sq_in;
      end

      if (rsp_load) begin
         one_way_ff     <= sample_ff;
         round_trip_ff  <= rt_ff;
         upper_bound_ff <= upper_in;
         status_ff      <= err_ff ? STATUS_NO_PROBE : STATUS_OK;
      end
   end

   assign req_ch.ready       = req_ready;
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.one_way     = one_way_ff;
   assign rsp_ch.round_trip  = round_trip_ff;
   assign rsp_ch.upper_bound = upper_bound_ff;
   assign rsp_ch.status      = status_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("fill level beyond window depth");

   a_reply_clears_pending: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_ch.req_type == REQ_REPLY) |=> !pending_ff)
      else $error("reply left the probe pending");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_MEAN_DIV) || (state_ff == ST_VAR_DIV))
      else $error("divider result arrived outside a divide state");

   a_sqrt_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sqrt_rsp.done |-> (state_ff == ST_SQRT))
      else $error("square root result arrived outside its state");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_NO_PROBE) |->
         (one_way_ff == '0) && (round_trip_ff == '0))
      else $error("error transaction carries latency values");

endmodule
`default_nettype wire

// ===== test/latency_window_upper_bound_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency window upper bound checker
// Watches the request, response and configuration channels. It keeps its own
// copy of the probe state, the sample window and the bound floor. It works out
// each reply's latencies and window bound when the request transaction is
// taken, then compares every response transaction against the oldest report
// still due.
// ----------------------------------------------------------------------------
module latency_window_upper_bound_check (
   input  logic  clock,
   input  logic  reset,
   lwub_req_if   req_ch,
   lwub_rsp_if   rsp_ch,
   lwub_csr_if   csr_ch,
   output int    mismatch_count,
   output int    reports_due
);
   import lwub_pkg::*;

   typedef struct packed {
      logic signed [TIME_W-1:0] one_way;
      logic signed [TIME_W-1:0] round_trip;
      logic signed [TIME_W-1:0] upper_bound;
      logic                     status;
   } latency_report_type;

   localparam longint BOUND_MAX = 64'sd2147483647;
   localparam longint BOUND_MIN = -64'sd2147483648;

   // Predicted block state
   logic signed [TIME_W-1:0] sample_window [WINDOW_DEPTH];
   logic [IDX_W-1:0]         fill_slot;
   int                       samples_held;
   logic                     probe_out;
   logic [TIME_W-1:0]        probe_sent_at;
   logic signed [TIME_W-1:0] prior_bound;
   logic [FLOOR_W-1:0]       floor_us;
   latency_report_type       report_queue [$];

   // Raise a bound to the configured floor
   function automatic logic signed [TIME_W-1:0] raise_to_floor(
      input logic signed [TIME_W-1:0] raw);
      logic signed [TIME_W-1:0] floor_ext;
      floor_ext = {{(TIME_W-FLOOR_W){1'b0}}, floor_us};
      if (longint'(raw) > longint'(floor_ext))
         return raw;
      return floor_ext;
   endfunction

   // Mean plus twice the root of the variance over the newest samples
   function automatic logic signed [TIME_W-1:0] window_bound();
      longint       total;
      longint       mean;
      longint       dev;
      longint       bound;
      logic [127:0] sq_sum;
      logic [63:0]  spread;
      logic [63:0]  mag;
      logic [63:0]  root;
      logic [63:0]  trial;
      int           slot;
      int           k;
      int           bit_pos;
      total  = 0;
      sq_sum = '0;
      for (k = 0; k < samples_held; k++) begin
         slot  = (int'(fill_slot) + WINDOW_DEPTH - 1 - k) % WINDOW_DEPTH;
         total += longint'(sample_window[slot]);
      end
      // floor the division, not truncate
      mean = total / longint'(samples_held);
      if ((total % longint'(samples_held)) != 0 && total < 0)
         mean--;
      for (k = 0; k < samples_held; k++) begin
         slot   = (int'(fill_slot) + WINDOW_DEPTH - 1 - k) % WINDOW_DEPTH;
         dev    = longint'(sample_window[slot]) - mean;
         mag    = (dev < 0) ? 64'(-dev) : 64'(dev);
         sq_sum += {64'd0, mag} * {64'd0, mag};
      end
      spread = 64'(sq_sum / 128'(samples_held));
      // integer square root, one bit at a time from the top
      root = '0;
      for (bit_pos = 31; bit_pos >= 0; bit_pos--) begin
         trial = root | (64'd1 << bit_pos);
         if (trial * trial <= spread)
            root = trial;
      end
      bound = mean + 2 * longint'(root);
      if (bound > BOUND_MAX)
         bound = BOUND_MAX;
      else if (bound < BOUND_MIN)
         bound = BOUND_MIN;
      return TIME_W'(bound);
   endfunction

   // Advance the predicted state by one request transaction
   task automatic predict_request(input logic kind, input logic [TIME_W-1:0] now,
                                  input logic [TIME_W-1:0] stamp);
      latency_report_type rep;
      if (kind == REQ_SEND) begin
         probe_sent_at = now;
         probe_out     = 1'b1;
      end else if (!probe_out) begin
         rep.one_way     = '0;
         rep.round_trip  = '0;
         rep.upper_bound = raise_to_floor(prior_bound);
         rep.status      = STATUS_NO_PROBE;
         report_queue    = {report_queue, rep};
      end else begin
         rep.one_way    = stamp - probe_sent_at;
         rep.round_trip = now - probe_sent_at;
         probe_out      = 1'b0;
         sample_window[fill_slot] = rep.one_way;
         fill_slot = IDX_W'((int'(fill_slot) + 1) % WINDOW_DEPTH);
         if (samples_held < WINDOW_DEPTH)
            samples_held++;
         prior_bound     = window_bound();
         rep.upper_bound = raise_to_floor(prior_bound);
         rep.status      = STATUS_OK;
         report_queue    = {report_queue, rep};
      end
   endtask

   function automatic void check_field(input string field,
                                       input logic signed [TIME_W-1:0] want,
                                       input logic signed [TIME_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Sample all three channels at the rising edge
   always @(posedge clock) begin
      latency_report_type due;
      if (reset) begin
         fill_slot      = '0;
         samples_held   = 0;
         probe_out      = 1'b0;
         probe_sent_at  = '0;
         prior_bound    = '0;
         floor_us       = FLOOR_RESET;
         mismatch_count = 0;
         report_queue.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready)
            floor_us = csr_ch.bound_floor_us;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (report_queue.size() == 0) begin
               $error("response transaction with none due: one_way %0d upper_bound %0d",
                      rsp_ch.one_way, rsp_ch.upper_bound);
               mismatch_count++;
            end else begin
               due = report_queue.pop_front();
               check_field("one_way", due.one_way, rsp_ch.one_way);
               check_field("round_trip", due.round_trip, rsp_ch.round_trip);
               check_field("upper_bound", due.upper_bound, rsp_ch.upper_bound);
               check_field("status", due.status, rsp_ch.status);
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_request(req_ch.req_type, req_ch.now_time, req_ch.reply_stamp);
      end
      reports_due = report_queue.size();
   end

endmodule

// ===== test/latency_window_upper_bound_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency window upper bound testbench
// Drives probe send and reply transactions: a directed opening on the time
// extremes and the no-probe and double-send cases, then random probe
// sequences under several bound floors and latency profiles, with bursty
// requests and a changing response stall pattern. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module latency_window_upper_bound_test;
   import lwub_pkg::*;

   localparam int STALL_LIMIT  = 6000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_ITEMS = 1500;
   localparam int PHASES       = 6;

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
   typedef enum {LAT_NEAR, LAT_EARLY, LAT_WIDE, LAT_STEADY} latency_profile_t;

   logic              clock;
   logic              reset;
   int                mismatch_count;
   int                reports_due;
   int                burst_left;
   int                items_sent;
   int                quiet_cycles = 0;
   logic [TIME_W-1:0] local_time_us;

   lwub_req_if req_ch ();
   lwub_rsp_if rsp_ch ();
   lwub_csr_if csr_ch ();

   latency_window_upper_bound dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   latency_window_upper_bound_check bound_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .reports_due    (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response stalls: switch between stall patterns after each random-length run
   initial begin : rsp_stall_pattern
      stall_mode_t mode;
      int          mode_left;
      int          cyc;
      rsp_ch.ready = 1'b0;
      mode         = STALL_NONE;
      mode_left    = 0;
      cyc          = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(64, 600);
         end
         mode_left--;
         cyc++;
         case (mode)
            STALL_NONE:  rsp_ch.ready = 1'b1;
            STALL_COIN:  rsp_ch.ready = 1'($urandom_range(0, 1));
            STALL_HEAVY: rsp_ch.ready = ($urandom_range(0, 7) == 0);
            default:     rsp_ch.ready = ((cyc % 9) < 4);
         endcase
      end
   end

   // Drop out when no channel has moved a transaction for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one request transaction, in bursts with random gaps between them
   task automatic push_item(input logic kind, input logic [TIME_W-1:0] now,
                            input logic [TIME_W-1:0] stamp);
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(25, 320)) @(negedge clock);
         else
            repeat ($urandom_range(1, 24)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid       = 1'b1;
      req_ch.req_type    = kind;
      req_ch.now_time    = now;
      req_ch.reply_stamp = stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_floor(input logic [FLOOR_W-1:0] value);
      csr_ch.valid          = 1'b1;
      csr_ch.bound_floor_us = value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Hold requests until every report is in and the block has gone quiet
   task automatic settle();
      req_ch.valid = 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [TIME_W-1:0] one_way_delay(input latency_profile_t profile);
      case (profile)
         LAT_NEAR:  return TIME_W'($urandom_range(0, 30000));
         LAT_EARLY: return TIME_W'($urandom_range(0, 42000)) - TIME_W'(40000);
         LAT_WIDE:  return $urandom();
         default: begin
            if ($urandom_range(0, 19) == 0)
               return TIME_W'($urandom_range(0, 2000000));
            return TIME_W'($urandom_range(4980, 5020));
         end
      endcase
   endfunction

   // Mostly clean send and reply pairs; the rest double sends and strays
   task automatic run_phase(input latency_profile_t profile, input int item_goal);
      logic [TIME_W-1:0] sent;
      logic [TIME_W-1:0] ow_delay;
      logic [TIME_W-1:0] rt_delay;
      int                pick;
      while (items_sent < item_goal) begin
         local_time_us += TIME_W'($urandom_range(1, 700000));
         sent     = local_time_us;
         ow_delay = one_way_delay(profile);
         rt_delay = (profile == LAT_WIDE) ? $urandom() : TIME_W'($urandom_range(0, 60000));
         pick     = $urandom_range(0, 99);
         if (pick < 80) begin
            push_item(REQ_SEND, sent, $urandom());
            push_item(REQ_REPLY, sent + rt_delay, sent + ow_delay);
         end else if (pick < 88) begin
            push_item(REQ_SEND, $urandom(), $urandom());
            push_item(REQ_SEND, sent, $urandom());
            push_item(REQ_REPLY, sent + rt_delay, sent + ow_delay);
         end else if (pick < 95) begin
            push_item(REQ_REPLY, $urandom(), $urandom());
         end else begin
            push_item(REQ_SEND, $urandom(), $urandom());
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.req_type       = REQ_SEND;
      req_ch.now_time       = '0;
      req_ch.reply_stamp    = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.bound_floor_us = FLOOR_RESET;
      burst_left            = 0;
      items_sent            = 0;
      local_time_us         = $urandom();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset floor, reply with nothing pending, wrap and extremes
      push_item(REQ_REPLY, 32'h0000_0000, 32'h0000_0000);
      push_item(REQ_SEND,  32'h0000_0000, 32'hFFFF_FFFF);
      push_item(REQ_REPLY, 32'h0000_0000, 32'h0000_0000);
      push_item(REQ_SEND,  32'hFFFF_FFFF, 32'h0000_0000);
      push_item(REQ_REPLY, 32'h0000_000F, 32'h0000_0000);
      // second send overwrites the first send time
      push_item(REQ_SEND,  32'h0000_1000, $urandom());
      push_item(REQ_SEND,  32'h0000_2000, $urandom());
      push_item(REQ_REPLY, 32'h0000_2100, 32'h0000_2050);
      push_item(REQ_REPLY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(REQ_SEND,  32'h0000_0000, $urandom());
      push_item(REQ_REPLY, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_item(REQ_SEND,  32'h0000_0000, $urandom());
      push_item(REQ_REPLY, 32'h8000_0000, 32'h8000_0000);
      push_item(REQ_SEND,  32'h8000_0000, $urandom());
      push_item(REQ_REPLY, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      // spread of extreme samples drives the bound into saturation
      push_item(REQ_SEND,  32'h0000_0000, $urandom());
      push_item(REQ_REPLY, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_item(REQ_SEND,  32'h0000_0000, 32'hFFFF_FFFF);
      push_item(REQ_REPLY, 32'h0000_0001, 32'h8000_0000);
      settle();
      write_floor(20'd1000000);
      push_item(REQ_REPLY, $urandom(), $urandom());
      settle();
      write_floor('0);
      push_item(REQ_REPLY, $urandom(), $urandom());

      // Random phases, each under its own floor and latency profile
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       write_floor('0);
            1:       write_floor(20'd1000000);
            2:       write_floor(20'h7FFFF);
            3:       write_floor(FLOOR_RESET);
            default: write_floor(FLOOR_W'($urandom_range(0, 1000000)));
         endcase
         local_time_us = $urandom();
         run_phase(latency_profile_t'((phase + 1) % 4), items_sent + RANDOM_ITEMS / PHASES);
      end

      settle();
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
